@@ rtl/ssu_pkg.sv @@
// Package for the stack sort unit.
// Holds the controller state type and the control struct broadcast to the sort cells.
// No dependencies.
package ssu_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } ssu_state_t;

  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic signed [DATA_W-1:0] x;
  } ssu_ctl_t;

endpackage

@@ rtl/stack_sort_with_aux_stack_unit.sv @@
// Top level of the stack sort unit: controller and a chain of DEPTH sort cells.
// Depends on ssu_pkg and ssu_cell.
//
// Usage: words arrive on the in_ channel, one signed 32-bit value per word. Each value is
// inserted in order into the cell chain in the cycle it is accepted, so loading runs at one
// word per cycle. Once DEPTH values are held, further values are dropped and the dropped
// flag is set for the batch. The word with in_tlast high is stored like any other and ends
// the batch. The block then emits the stored values in ascending order on the out_ channel,
// one word per cycle while out_tready is high, starting the cycle after the last input word.
// out_tlast marks the final value and out_tuser carries the dropped flag on every word.
// While a batch is being emitted in_tready is low; a stall on out_tready simply holds the
// head word. After the final word the block returns to loading with an empty chain.
// Reset (rst_n low, synchronous) empties the chain and clears the dropped flag.
module stack_sort_with_aux_stack_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ssu_pkg::DATA_W-1:0]    in_tdata,   // [31:0] value
  input  logic                          in_tlast,   // last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ssu_pkg::DATA_W-1:0]    out_tdata,  // [31:0] sorted_value
  output logic                          out_tlast,  // end_of_run
  output logic                          out_tuser   // [0] dropped
);
  import ssu_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssu_state_t state_r;
  ssu_state_t state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  logic in_acc;
  logic out_acc;
  logic full;
  ssu_ctl_t ctl;

  logic                     shift [DEPTH];
  logic signed [DATA_W-1:0] val   [DEPTH];
  logic                     vld   [DEPTH];

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign full    = (count_r == CNT_W'(DEPTH));

  assign ctl.ins = in_acc && !full;
  assign ctl.pop = out_acc;
  assign ctl.x   = $signed(in_tdata);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && count_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_LOAD);
    out_tvalid = (state_r == ST_EMIT);
    out_tdata  = val[0];
    out_tlast  = (count_r == CNT_W'(1));
    out_tuser  = ovf_r;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (in_acc) begin
      ovf_nxt = 1'b1;
    end
    if (out_acc) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     p_shift;
    logic signed [DATA_W-1:0] p_val;
    logic                     p_vld;
    logic signed [DATA_W-1:0] n_val;
    logic                     n_vld;

    if (i == 0) begin : g_head
      assign p_shift = 1'b0;
      assign p_val   = '0;
      assign p_vld   = 1'b0;
    end else begin : g_body
      assign p_shift = shift[i-1];
      assign p_val   = val[i-1];
      assign p_vld   = vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_val = '0;
      assign n_vld = 1'b0;
    end else begin : g_mid
      assign n_val = val[i+1];
      assign n_vld = vld[i+1];
    end

    ssu_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_shift (p_shift),
      .prev_val   (p_val),
      .prev_vld   (p_vld),
      .next_val   (n_val),
      .next_vld   (n_vld),
      .shift      (shift[i]),
      .val        (val[i]),
      .vld        (vld[i])
    );
  end

endmodule

@@ rtl/ssu_cell.sv @@
// One cell of the insertion chain of the stack sort unit.
// Depends on ssu_pkg for the control struct and data width.
// Holds one value and its valid bit; inserts in order and shifts toward the head on a pop.
module ssu_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssu_pkg::ssu_ctl_t                ctl,
  input  logic                             prev_shift,
  input  logic signed [ssu_pkg::DATA_W-1:0] prev_val,
  input  logic                             prev_vld,
  input  logic signed [ssu_pkg::DATA_W-1:0] next_val,
  input  logic                             next_vld,
  output logic                             shift,
  output logic signed [ssu_pkg::DATA_W-1:0] val,
  output logic                             vld
);
  import ssu_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;
  logic                     vld_r;
  logic                     vld_nxt;

  assign shift = !vld_r || (val_r > ctl.x);
  assign val   = val_r;
  assign vld   = vld_r;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.pop) begin
      val_nxt = next_val;
      vld_nxt = next_vld;
    end else if (ctl.ins && shift) begin
      if (prev_shift) begin
        val_nxt = prev_val;
        vld_nxt = prev_vld;
      end else begin
        val_nxt = ctl.x;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ tb/sv/tb_stack_sort_with_aux_stack_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stack sort unit: streams batches of signed words in,
// predicts the ascending emission with the dropped flag, and checks every output word.
// Depends on ssu_pkg and stack_sort_with_aux_stack_unit.
module tb_stack_sort_with_aux_stack_unit;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned W = ssu_pkg::DATA_W;
  localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};

  typedef logic signed [W-1:0] value_t;

  typedef struct packed {
    value_t val;
    logic   last;
  } in_word_t;

  typedef struct packed {
    value_t val;
    logic   eor;
    logic   drop;
  } sorted_word_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [W-1:0] in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [W-1:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;

  in_word_t     pending_words[$];
  value_t       batch_order[$];
  logic         batch_dropped = 1'b0;
  sorted_word_t awaited_words[$];
  int           fails      = 0;
  int           in_gap     = 0;
  int           out_stall  = 0;
  bit           in_steady  = 1'b0;
  bit           out_steady = 1'b0;

  stack_sort_with_aux_stack_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // The batch is kept in ascending order as it arrives; the last word releases it.
  function automatic void sort_into_batch(value_t v, logic last);
    int pos;
    sorted_word_t w;
    if (batch_order.size() < DEPTH) begin
      pos = 0;
      while (pos < batch_order.size() && batch_order[pos] <= v) pos++;
      batch_order.insert(pos, v);
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      foreach (batch_order[i]) begin
        w.val  = batch_order[i];
        w.eor  = (i == batch_order.size() - 1);
        w.drop = batch_dropped;
        awaited_words.push_back(w);
      end
      batch_order.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  task automatic queue_word(value_t v, logic last);
    in_word_t w;
    w.val  = v;
    w.last = last;
    pending_words.push_back(w);
  endtask

  always @(posedge clk) begin : drive_proc
    logic     nxt_valid;
    in_word_t w;
    nxt_valid = in_tvalid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sort_into_batch(in_tdata, in_tlast);
        nxt_valid = 1'b0;
        if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
        in_gap = in_steady ? 0 : $urandom_range(0, 6);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_tdata  <= w.val;
          in_tlast  <= w.last;
          nxt_valid = 1'b1;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  always @(posedge clk) begin : check_proc
    sorted_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected word: sorted_value %0d", $signed(out_tdata));
          fails++;
        end else begin
          want = awaited_words.pop_front();
          if (out_tdata !== want.val) begin
            $error("sorted_value: expected %0d, actual %0d", want.val, $signed(out_tdata));
            fails++;
          end
          if (out_tlast !== want.eor) begin
            $error("end_of_run: expected %0b, actual %0b", want.eor, out_tlast);
            fails++;
          end
          if (out_tuser !== want.drop) begin
            $error("dropped: expected %0b, actual %0b", want.drop, out_tuser);
            fails++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
        out_stall = out_steady ? 0 : $urandom_range(0, 6);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_tready <= (out_stall == 0);
    end
  end

  initial begin : stimulus
    int     n_words;
    int     len;
    value_t v;

    // Single-word batches at both extremes.
    queue_word(VAL_MAX, 1'b1);
    queue_word(VAL_MIN, 1'b1);
    // Duplicates, signs and extremes mixed in one batch.
    queue_word(5, 1'b0);
    queue_word(-5, 1'b0);
    queue_word(5, 1'b0);
    queue_word(0, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(VAL_MIN, 1'b0);
    queue_word(VAL_MAX, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(0, 1'b1);
    // Already descending and already ascending arrivals.
    queue_word(3, 1'b0);
    queue_word(2, 1'b0);
    queue_word(1, 1'b1);
    queue_word(1, 1'b0);
    queue_word(2, 1'b0);
    queue_word(3, 1'b1);

    n_words = 0;
    while (n_words < 250) begin
      if (n_words == 0) begin
        len = DEPTH + 2;
      end else if (n_words == DEPTH + 2) begin
        len = DEPTH;
      end else begin
        case ($urandom_range(0, 24))
          0, 1:    len = $urandom_range(DEPTH + 1, DEPTH + 8);
          2, 3, 4: len = $urandom_range(13, DEPTH);
          default: len = $urandom_range(1, 12);
        endcase
      end
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0:       v = $signed($urandom_range(0, 8)) - 4;
          1:       v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
          default: v = $urandom;
        endcase
        queue_word(v, i == len - 1);
      end
      n_words += len;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid || awaited_words.size() != 0)
      @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ssu_pkg.sv
rtl/ssu_cell.sv
rtl/stack_sort_with_aux_stack_unit.sv
tb/sv/tb_stack_sort_with_aux_stack_unit.sv
